// ===== rtl/gld_pkg.sv =====
// Shared types and codes for the GIF LZW decoder.
// No dependencies; used by gif_lzw_decoder and gld_checker.
package gld_pkg;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_MORE  = 2'd1,
      KIND_END   = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_SIZE   = 2'd0,
      PH_LEN    = 2'd1,
      PH_DATA   = 2'd2,
      PH_CLOSED = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CODE,
      ST_WALK,
      ST_TBLRD,
      ST_FIN,
      ST_POP,
      ST_POPD,
      ST_EMIT
   } state_type;

   localparam int BUF_W      = 24;
   localparam int HELD_W     = 5;
   localparam int MAX_ROOT   = 11;
   localparam int BYTE_LIMIT = 16;

endpackage

// ===== rtl/gif_lzw_decoder.sv =====
// GIF LZW decoder top level: sub-block unframing, code extraction, string table
// and reversal stack. Depends on gld_pkg.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata: data_byte[7:0]; tuser: cmd (0 push, 1 request)
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: pixel[7:0]; tuser: kind[1:0]; tlast: string_end
//
// A request popping a buffered pixel goes through POP, POPD and EMIT to the output
// register; one that decodes a new code takes codes from the bit buffer in CODE, walks
// the prefix chain (WALK, plus a table memory read (TBLRD) per link), then goes through
// FIN, POP, POPD and EMIT. Synchronous active-high reset clears control state; the
// memories need no clear. Requests are taken only while the sequencer is idle; pushes
// and requests are still taken while a finished result waits in the output register.
module gif_lzw_decoder #(
   parameter int MAX_CODE_BITS = 12,
   parameter int TABLE_DEPTH   = 4096,
   parameter int STACK_DEPTH   = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] pixel
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);
   import gld_pkg::*;

   localparam int CW  = MAX_CODE_BITS;
   localparam int TW  = $clog2(TABLE_DEPTH);
   localparam int SW  = $clog2(STACK_DEPTH);
   localparam int NFW = ((CW > TW) ? CW : TW) + 1;

   // memories
   logic [CW-1:0] prefix_mem [TABLE_DEPTH];
   logic [7:0]    suffix_mem [TABLE_DEPTH];
   logic [7:0]    stack_mem  [STACK_DEPTH];

   logic          tbl_we;
   logic [TW-1:0] tbl_waddr, tbl_raddr;
   logic [CW-1:0] tbl_wprefix, prefix_q;
   logic [7:0]    tbl_wsuffix, suffix_q;
   logic          stk_we;
   logic [SW-1:0] stk_waddr, stk_raddr;
   logic [7:0]    stk_wdata, stk_q;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         prefix_mem[tbl_waddr] <= tbl_wprefix;
         suffix_mem[tbl_waddr] <= tbl_wsuffix;
      end
      prefix_q <= prefix_mem[tbl_raddr];
      suffix_q <= suffix_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_q <= stack_mem[stk_raddr];
   end

   // registers
   state_type      state_ff, state_in;
   phase_type      phase_ff, phase_in;
   kind_type       halt_ff, halt_in;
   logic [3:0]     root_ff, root_in;
   logic [3:0]     width_ff, width_in;
   logic [NFW-1:0] free_ff, free_in;
   logic [CW-1:0]  prev_ff, prev_in;
   logic           first_flag_ff, first_flag_in;
   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [7:0]     remain_ff, remain_in;
   logic [SW:0]    count_ff, count_in;
   logic [SW:0]    sp_ff, sp_in;
   logic [CW-1:0]  code_ff, code_in;
   logic [CW-1:0]  chain_ff, chain_in;
   logic           kw_ff, kw_in;
   logic [7:0]     lead_ff, lead_in;
   kind_type       res_kind_ff, res_kind_in;
   logic [7:0]     res_pixel_ff, res_pixel_in;
   logic           res_end_ff, res_end_in;
   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       rsp_kind_ff, rsp_kind_in;
   logic [7:0]     rsp_pixel_ff, rsp_pixel_in;
   logic           rsp_last_ff, rsp_last_in;

   // helpers
   logic [NFW-1:0] clear_code, code_ext, chain_ext, free_inc;
   logic [CW-1:0]  cur_code;
   logic [BUF_W-1:0] code_mask;
   logic [CW+TW-1:0] chain_wide, free_wide;
   logic [31:0]    push_shift;
   logic           accept;

   assign clear_code = NFW'(1) << root_ff;
   assign code_mask  = ~({BUF_W{1'b1}} << width_ff);
   assign cur_code   = CW'(buf_ff & code_mask);
   assign code_ext   = NFW'(cur_code);
   assign chain_ext  = NFW'(chain_ff);
   assign chain_wide = {{TW{1'b0}}, chain_ff};
   assign free_wide  = (CW + TW)'(free_ff);
   assign free_inc   = free_ff + NFW'(1);
   assign push_shift = {24'd0, req_tdata} << held_ff;
   assign accept     = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_SIZE;
         halt_ff       <= KIND_PIXEL;
         root_ff       <= '0;
         width_ff      <= '0;
         free_ff       <= '0;
         prev_ff       <= '0;
         first_flag_ff <= 1'b1;
         buf_ff        <= '0;
         held_ff       <= '0;
         remain_ff     <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         halt_ff       <= halt_in;
         root_ff       <= root_in;
         width_ff      <= width_in;
         free_ff       <= free_in;
         prev_ff       <= prev_in;
         first_flag_ff <= first_flag_in;
         buf_ff        <= buf_in;
         held_ff       <= held_in;
         remain_ff     <= remain_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff        <= sp_in;
      code_ff      <= code_in;
      chain_ff     <= chain_in;
      kw_ff        <= kw_in;
      lead_ff      <= lead_in;
      res_kind_ff  <= res_kind_in;
      res_pixel_ff <= res_pixel_in;
      res_end_ff   <= res_end_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      halt_in       = halt_ff;
      root_in       = root_ff;
      width_in      = width_ff;
      free_in       = free_ff;
      prev_in       = prev_ff;
      first_flag_in = first_flag_ff;
      buf_in        = buf_ff;
      held_in       = held_ff;
      remain_in     = remain_ff;
      count_in      = count_ff;
      sp_in         = sp_ff;
      code_in       = code_ff;
      chain_in      = chain_ff;
      kw_in         = kw_ff;
      lead_in       = lead_ff;
      res_kind_in   = res_kind_ff;
      res_pixel_in  = res_pixel_ff;
      res_end_in    = res_end_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      tbl_we        = 1'b0;
      tbl_waddr     = free_wide[TW-1:0];
      tbl_wprefix   = prev_ff;
      tbl_wsuffix   = lead_ff;
      tbl_raddr     = chain_wide[TW-1:0];
      stk_we        = 1'b0;
      stk_waddr     = sp_ff[SW-1:0];
      stk_wdata     = '0;
      stk_raddr     = SW'(count_ff - (SW + 1)'(1));

      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_tuser) begin
               // push one stream byte
               if (halt_ff == KIND_PIXEL) begin
                  case (phase_ff)
                     PH_SIZE: begin
                        if (req_tdata > 8'(MAX_ROOT) ||
                            (9'(req_tdata) + 9'd1) > 9'(MAX_CODE_BITS)) begin
                           halt_in  = KIND_ERROR;
                           count_in = '0;
                        end else begin
                           root_in       = req_tdata[3:0];
                           width_in      = req_tdata[3:0] + 4'd1;
                           free_in       = (NFW'(1) << req_tdata[3:0]) + NFW'(2);
                           first_flag_in = 1'b1;
                           phase_in      = PH_LEN;
                        end
                     end
                     PH_LEN: begin
                        if (req_tdata == 8'd0) begin
                           phase_in = PH_CLOSED;
                        end else begin
                           remain_in = req_tdata;
                           phase_in  = PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        if (held_ff > HELD_W'(BYTE_LIMIT)) begin
                           halt_in  = KIND_ERROR;
                           count_in = '0;
                        end else begin
                           buf_in    = buf_ff | push_shift[BUF_W-1:0];
                           held_in   = held_ff + HELD_W'(8);
                           remain_in = remain_ff - 8'd1;
                           if (remain_ff == 8'd1) begin
                              phase_in = PH_LEN;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end else if (accept) begin
               res_pixel_in = '0;
               res_end_in   = 1'b0;
               if (halt_ff != KIND_PIXEL) begin
                  res_kind_in = halt_ff;
                  state_in    = ST_EMIT;
               end else if (phase_ff == PH_SIZE) begin
                  res_kind_in = KIND_MORE;
                  state_in    = ST_EMIT;
               end else if (count_ff != '0) begin
                  state_in = ST_POP;
               end else begin
                  state_in = ST_CODE;
               end
            end
         end

         ST_CODE: begin
            res_pixel_in = '0;
            res_end_in   = 1'b0;
            if (held_ff < HELD_W'(width_ff)) begin
               if (phase_ff == PH_CLOSED) begin
                  halt_in     = KIND_ERROR;
                  count_in    = '0;
                  res_kind_in = KIND_ERROR;
               end else begin
                  res_kind_in = KIND_MORE;
               end
               state_in = ST_EMIT;
            end else begin
               buf_in  = buf_ff >> width_ff;
               held_in = held_ff - HELD_W'(width_ff);
               code_in = cur_code;
               kw_in   = 1'b0;
               if (code_ext == clear_code) begin
                  // clear: restart width and table, take the next code
                  width_in      = root_ff + 4'd1;
                  free_in       = clear_code + NFW'(2);
                  first_flag_in = 1'b1;
               end else if (code_ext == clear_code + NFW'(1)) begin
                  halt_in     = KIND_END;
                  count_in    = '0;
                  res_kind_in = KIND_END;
                  state_in    = ST_EMIT;
               end else if (code_ext < clear_code ||
                            (code_ext < free_ff && code_ext < NFW'(TABLE_DEPTH))) begin
                  chain_in = cur_code;
                  sp_in    = '0;
                  state_in = ST_WALK;
               end else if (code_ext == free_ff && !first_flag_ff) begin
                  // code not yet in the table: reserve the bottom slot for its lead pixel
                  kw_in     = 1'b1;
                  chain_in  = prev_ff;
                  stk_we    = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = '0;
                  sp_in     = (SW + 1)'(1);
                  state_in  = ST_WALK;
               end else begin
                  halt_in     = KIND_ERROR;
                  count_in    = '0;
                  res_kind_in = KIND_ERROR;
                  state_in    = ST_EMIT;
               end
            end
         end

         ST_WALK: begin
            if (sp_ff >= (SW + 1)'(STACK_DEPTH) ||
                (chain_ext >= clear_code && chain_ext >= NFW'(TABLE_DEPTH))) begin
               halt_in      = KIND_ERROR;
               count_in     = '0;
               res_kind_in  = KIND_ERROR;
               res_pixel_in = '0;
               res_end_in   = 1'b0;
               state_in     = ST_EMIT;
            end else if (chain_ext < clear_code) begin
               stk_we    = 1'b1;
               stk_wdata = chain_ff[7:0];
               sp_in     = sp_ff + (SW + 1)'(1);
               lead_in   = chain_ff[7:0];
               state_in  = ST_FIN;
            end else begin
               state_in = ST_TBLRD;
            end
         end

         ST_TBLRD: begin
            stk_we    = 1'b1;
            stk_wdata = suffix_q;
            sp_in     = sp_ff + (SW + 1)'(1);
            chain_in  = prefix_q;
            state_in  = ST_WALK;
         end

         ST_FIN: begin
            if (kw_ff) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = lead_ff;
            end
            if (!first_flag_ff && free_ff < NFW'(TABLE_DEPTH)) begin
               tbl_we  = 1'b1;
               free_in = free_inc;
               if (free_inc == (NFW'(1) << width_ff) && width_ff < 4'(MAX_CODE_BITS)) begin
                  width_in = width_ff + 4'd1;
               end
            end else if (free_ff == (NFW'(1) << width_ff) &&
                         width_ff < 4'(MAX_CODE_BITS)) begin
               width_in = width_ff + 4'd1;
            end
            prev_in       = code_ff;
            first_flag_in = 1'b0;
            count_in      = sp_ff;
            state_in      = ST_POP;
         end

         ST_POP: begin
            count_in = count_ff - (SW + 1)'(1);
            state_in = ST_POPD;
         end

         ST_POPD: begin
            res_kind_in  = KIND_PIXEL;
            res_pixel_in = stk_q;
            res_end_in   = (count_ff == '0);
            state_in     = ST_EMIT;
         end

         ST_EMIT: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_pixel_in = res_pixel_ff;
               rsp_last_in  = res_end_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/gld_checker.sv =====
// Port-level checks for the GIF LZW decoder, bound to its top level.
// Depends on gld_pkg and gif_lzw_decoder.
module gld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);
   import gld_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result dropped or changed while stalled");

   a_last_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PIXEL)
      else $error("string end on a non-pixel result");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_PIXEL |-> rsp_tdata == 8'd0)
      else $error("status result carries pixel data");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_ERROR ##1 rsp_tvalid
      |-> rsp_tuser == KIND_ERROR)
      else $error("result after an error is not an error");

endmodule

bind gif_lzw_decoder gld_checker u_gld_checker (.*);
